// File: rtl/gtdl_pkg.sv
package gtdl_pkg;

  localparam int FIELD_W    = 32;
  localparam int ADDR_W     = 15;
  localparam int DEPTH      = 32768;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 31;
  localparam int DIM_REG_W  = 6;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_MAX_DIM    = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_STEP = 3'd3,
    CFG_GRID_NX  = 3'd4,
    CFG_GRID_NY  = 3'd5,
    CFG_GRID_NZ  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic v;
    logic q;
    logic outside;
  } ctrl_t;

endpackage

// File: rtl/gtdl_ram.sv
module gtdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gtdl_lerp.sv
module gtdl_lerp #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic signed [W-1:0]  a,
  input  logic signed [W-1:0]  b,
  input  logic signed [16:0]   f,
  output logic signed [W-1:0]  y
);

  localparam logic signed [W+2:0] VMAX = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] VMIN = {4'b1111, {(W-1){1'b0}}};

  logic signed [W:0]    d;
  logic signed [W+17:0] prod;
  logic signed [W+17:0] biased;
  logic signed [W+17:0] shifted;
  logic signed [W+2:0]  sum;
  logic signed [W-1:0]  a_d;

  assign d = $signed({b[W-1], b}) - $signed({a[W-1], a});

  always_ff @(posedge clk) begin
    prod <= d * f;
    a_d  <= a;
  end

  // divide by 65536 rounding toward zero
  assign biased  = prod + $signed({{(W+2){1'b0}}, {16{prod[W+17]}}});
  assign shifted = biased >>> 16;
  assign sum     = $signed({{3{a_d[W-1]}}, a_d}) + shifted[W+2:0];

  always_ff @(posedge clk) begin
    if (sum > VMAX) begin
      y <= VMAX[W-1:0];
    end else if (sum < VMIN) begin
      y <= VMIN[W-1:0];
    end else begin
      y <= sum[W-1:0];
    end
  end

endmodule

// File: rtl/grid_trilinear_distance_lookup.sv
// Trilinear lookup in a signed distance grid (Q16.16).
// Input channel: an item is taken at a clock edge with start high and busy
// low; busy stays low, so an item may be started in every cycle. action
// selects a sample write (cell_address, cell_value) or a point query
// (point_x/y/z).
// Configuration: each cfg_write edge writes the one register that cfg_index
// selects (origin x/y/z, inv_step or a grid size) from cfg_data; change it
// only while no items are in flight.
// Result channel: each query gives one result, done high for one cycle with
// distance and outside. Writes give none. The receiver cannot stall.
// Path of a query: input, offset, scale, index and address stages, store read, x, y and z blends, then done.
// Throughput: one item per cycle. The eight corner samples come from eight
// copies of the store, each written by every write item at the same stage
// where queries read, so item order is kept.
// Reset clears the pipeline and returns the configuration registers to their
// defaults; the store contents are undefined until written.
module grid_trilinear_distance_lookup #(
  parameter int MAX_DIM    = gtdl_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = gtdl_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic signed [31:0]              point_x,
  input  logic signed [31:0]              point_y,
  input  logic signed [31:0]              point_z,
  input  logic [gtdl_pkg::ADDR_W-1:0]     cell_address,
  input  logic signed [31:0]              cell_value,
  input  logic                            cfg_write,
  input  logic [gtdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  output logic                            done,
  output logic signed [31:0]              distance,
  output logic                            outside
);

  localparam int E     = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int AW    = gtdl_pkg::ADDR_W;
  localparam logic signed [E-1:0] VMIN_E = {1'b1, {(E-1){1'b0}}};

  // configuration
  logic signed [31:0]               origin [3];
  logic [gtdl_pkg::STEP_W-1:0]      inv_step;
  logic [gtdl_pkg::DIM_REG_W-1:0]   dim_reg [3];
  logic [DIM_W-1:0]                 dim_eff [3];

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [gtdl_pkg::DIM_REG_W-1:0] n);
    logic [DIM_W-1:0] r;
    if (int'(n) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(n);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0]  <= '0;
      origin[1]  <= '0;
      origin[2]  <= '0;
      inv_step   <= gtdl_pkg::STEP_W'(65536);
      dim_reg[0] <= gtdl_pkg::DIM_REG_W'(32);
      dim_reg[1] <= gtdl_pkg::DIM_REG_W'(32);
      dim_reg[2] <= gtdl_pkg::DIM_REG_W'(32);
    end else if (cfg_write) begin
      unique case (cfg_index)
        gtdl_pkg::CFG_ORIGIN_X: origin[0]  <= cfg_data;
        gtdl_pkg::CFG_ORIGIN_Y: origin[1]  <= cfg_data;
        gtdl_pkg::CFG_ORIGIN_Z: origin[2]  <= cfg_data;
        gtdl_pkg::CFG_INV_STEP: inv_step   <= cfg_data[gtdl_pkg::STEP_W-1:0];
        gtdl_pkg::CFG_GRID_NX:  dim_reg[0] <= cfg_data[gtdl_pkg::DIM_REG_W-1:0];
        gtdl_pkg::CFG_GRID_NY:  dim_reg[1] <= cfg_data[gtdl_pkg::DIM_REG_W-1:0];
        gtdl_pkg::CFG_GRID_NZ:  dim_reg[2] <= cfg_data[gtdl_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dim_eff[a] = clamp_dim(dim_reg[a]);
    end
  end

  assign busy = 1'b0;

  // stage 1: input register
  logic               v1, q1;
  logic signed [31:0] pt1 [3];
  logic [AW-1:0]      waddr1;
  logic [E-1:0]       wdata1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    q1     <= (action == gtdl_pkg::ACT_QUERY);
    pt1[0] <= point_x;
    pt1[1] <= point_y;
    pt1[2] <= point_z;
    waddr1 <= cell_address;
    wdata1 <= cell_value[E-1:0];
  end

  // stage 2: offset from origin
  logic               v2, q2;
  logic signed [32:0] diff2 [3];
  logic [AW-1:0]      waddr2;
  logic [E-1:0]       wdata2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    q2 <= q1;
    for (int a = 0; a < 3; a++) begin
      diff2[a] <= $signed({pt1[a][31], pt1[a]}) - $signed({origin[a][31], origin[a]});
    end
    waddr2 <= waddr1;
    wdata2 <= wdata1;
  end

  // stage 3: scale by inverse step, exact Q32.32
  logic               v3, q3;
  logic signed [63:0] prod3 [3];
  logic [AW-1:0]      waddr3;
  logic [E-1:0]       wdata3;
  logic signed [64:0] prod_full [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_full[a] = diff2[a] * $signed({1'b0, inv_step});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    q3 <= q2;
    for (int a = 0; a < 3; a++) begin
      prod3[a] <= prod_full[a][63:0];
    end
    waddr3 <= waddr2;
    wdata3 <= wdata2;
  end

  // stage 4: cell index, weight, range check
  logic               v4, q4, out4;
  logic [IDX_W-1:0]   idx4 [3];
  logic signed [16:0] frac4 [3];
  logic [AW-1:0]      waddr4;
  logic [E-1:0]       wdata4;
  logic               neg3 [3];
  logic [63:0]        mag3 [3];
  logic [31:0]        ip3 [3];
  logic [15:0]        fm3 [3];
  logic signed [33:0] lim3 [3];
  logic [2:0]         axis_out3;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      neg3[a] = prod3[a][63];
      mag3[a] = neg3[a] ? 64'(-prod3[a]) : 64'(prod3[a]);
      ip3[a]  = mag3[a][63:32];
      fm3[a]  = mag3[a][31:16];
      lim3[a] = $signed({{(34-DIM_W){1'b0}}, dim_eff[a]}) - 34'sd2;
      // truncation toward zero: (-1,0) maps to cell 0 with a negative weight
      axis_out3[a] = (neg3[a] && (ip3[a] != 32'd0)) ||
                     ($signed({2'b00, ip3[a]}) > lim3[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    q4   <= q3;
    out4 <= |axis_out3;
    for (int a = 0; a < 3; a++) begin
      idx4[a]  <= ip3[a][IDX_W-1:0];
      frac4[a] <= neg3[a] ? -$signed({1'b0, fm3[a]}) : $signed({1'b0, fm3[a]});
    end
    waddr4 <= waddr3;
    wdata4 <= wdata3;
  end

  // stage 5: y + ny*z for the four (y,z) corners, mod 2^15
  logic               v5, q5, out5;
  logic [IDX_W-1:0]   i5;
  logic [AW-1:0]      yz5 [4];
  logic signed [16:0] fx5, fy5, fz5;
  logic [AW-1:0]      waddr5;
  logic [E-1:0]       wdata5;
  logic [AW-1:0]      nx15, ny15, j4, k4;

  assign nx15 = AW'(dim_eff[0]);
  assign ny15 = AW'(dim_eff[1]);
  assign j4   = AW'(idx4[1]);
  assign k4   = AW'(idx4[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    q5   <= q4;
    out5 <= out4;
    i5   <= idx4[0];
    for (int c = 0; c < 4; c++) begin
      yz5[c] <= AW'(j4 + AW'(c % 2)) + AW'(ny15 * AW'(k4 + AW'(c / 2)));
    end
    fx5    <= frac4[0];
    fy5    <= frac4[1];
    fz5    <= frac4[2];
    waddr5 <= waddr4;
    wdata5 <= wdata4;
  end

  // corner addresses; store copies are read and written at this stage
  logic [AW-1:0]      raddr [8];
  logic [E-1:0]       corner [8];
  logic               ram_we;

  assign ram_we = v5 && !q5;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      raddr[c] = AW'(AW'(i5) + AW'(c % 2)) + AW'(nx15 * yz5[c / 2]);
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_bank
    gtdl_ram #(
      .WIDTH (E),
      .DEPTH (gtdl_pkg::DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (waddr5),
      .wdata (wdata5),
      .raddr (raddr[c]),
      .rdata (corner[c])
    );
  end

  // control and weights ride alongside the blend stages
  gtdl_pkg::ctrl_t    ctrl [7];
  logic signed [16:0] fx6;
  logic signed [16:0] fy_d [3];
  logic signed [16:0] fz_d [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 7; s++) begin
        ctrl[s].v <= 1'b0;
      end
    end else begin
      ctrl[0].v <= v5;
      for (int s = 1; s < 7; s++) begin
        ctrl[s].v <= ctrl[s-1].v;
      end
    end
    ctrl[0].q       <= q5;
    ctrl[0].outside <= out5;
    for (int s = 1; s < 7; s++) begin
      ctrl[s].q       <= ctrl[s-1].q;
      ctrl[s].outside <= ctrl[s-1].outside;
    end
    fx6     <= fx5;
    fy_d[0] <= fy5;
    fz_d[0] <= fz5;
    for (int s = 1; s < 3; s++) begin
      fy_d[s] <= fy_d[s-1];
    end
    for (int s = 1; s < 5; s++) begin
      fz_d[s] <= fz_d[s-1];
    end
  end

  // four blends along x, two along y, one along z
  logic signed [E-1:0] lx [4];
  logic signed [E-1:0] ly [2];
  logic signed [E-1:0] lz;

  for (genvar p = 0; p < 4; p++) begin : g_lx
    gtdl_lerp #(.W(E)) u_lerp (
      .clk (clk),
      .a   (corner[2*p]),
      .b   (corner[2*p+1]),
      .f   (fx6),
      .y   (lx[p])
    );
  end

  for (genvar p = 0; p < 2; p++) begin : g_ly
    gtdl_lerp #(.W(E)) u_lerp (
      .clk (clk),
      .a   (lx[2*p]),
      .b   (lx[2*p+1]),
      .f   (fy_d[2]),
      .y   (ly[p])
    );
  end

  gtdl_lerp #(.W(E)) u_lz (
    .clk (clk),
    .a   (ly[0]),
    .b   (ly[1]),
    .f   (fz_d[4]),
    .y   (lz)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl[6].v && ctrl[6].q;
    end
    outside  <= ctrl[6].outside;
    distance <= ctrl[6].outside ? 32'(VMIN_E) : 32'(lz);
  end

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> v1)
    else $error("accepted item did not enter the pipeline");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (v5 && !q5) |-> ##8 !done)
    else $error("write item produced a result");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (v5 && q5) |-> ##8 done)
    else $error("query item lost");

  a_outside_value: assert property (@(posedge clk) disable iff (rst)
    (done && outside) |-> (distance == 32'(VMIN_E)))
    else $error("outside result without flag distance");
`endif

endmodule

// File: tb/sv/grid_trilinear_distance_lookup_chk.sv
module grid_trilinear_distance_lookup_chk (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            action,
  input  logic signed [31:0]              point_x,
  input  logic signed [31:0]              point_y,
  input  logic signed [31:0]              point_z,
  input  logic [gtdl_pkg::ADDR_W-1:0]     cell_address,
  input  logic signed [31:0]              cell_value,
  input  logic                            cfg_write,
  input  logic [gtdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            done,
  input  logic signed [31:0]              distance,
  input  logic                            outside,
  output int                              errors,
  output int                              pending,
  output int                              n_lookups,
  output int                              n_outside
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] dval;
    logic               outs;
  } lookup_t;

  lookup_t             lookup_q[$];
  logic [31:0]         grid_mem [gtdl_pkg::DEPTH];
  longint              org [3];
  longint              step_inv;
  longint              dim [3];

  function automatic longint clamp_dim(longint n);
    return (n > gtdl_pkg::DEF_MAX_DIM) ? gtdl_pkg::DEF_MAX_DIM : n;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return sat32(a + ((b - a) * f) / 65536);
  endfunction

  // cell index and signed Q0.16 weight; 0 when the axis falls outside
  function automatic bit map_axis(longint p, longint o, longint n,
                                  output longint idx, output longint frac);
    longint prod, mag, ip, fm;
    prod = (p - o) * step_inv;
    mag  = (prod < 0) ? -prod : prod;
    ip   = mag >>> 32;
    fm   = (mag >>> 16) & 64'hFFFF;
    idx  = ip;
    frac = (prod < 0) ? -fm : fm;
    if (prod < 0 && ip != 0) return 0;
    if (ip > clamp_dim(n) - 2) return 0;
    return 1;
  endfunction

  function automatic longint corner(longint x, longint y, longint z);
    longint a;
    a = x + clamp_dim(dim[0]) * (y + clamp_dim(dim[1]) * z);
    return longint'(signed'(grid_mem[a & (gtdl_pkg::DEPTH - 1)]));
  endfunction

  function automatic lookup_t predict_lookup(longint px, longint py, longint pz);
    lookup_t r;
    longint i, j, k, fx, fy, fz, a, b, c, d;
    if (!map_axis(px, org[0], dim[0], i, fx) || !map_axis(py, org[1], dim[1], j, fy) ||
        !map_axis(pz, org[2], dim[2], k, fz)) begin
      r.dval = 32'sh8000_0000;
      r.outs = 1'b1;
      return r;
    end
    a = blend(corner(i, j, k), corner(i + 1, j, k), fx);
    b = blend(corner(i, j + 1, k), corner(i + 1, j + 1, k), fx);
    c = blend(corner(i, j, k + 1), corner(i + 1, j, k + 1), fx);
    d = blend(corner(i, j + 1, k + 1), corner(i + 1, j + 1, k + 1), fx);
    r.dval = 32'(blend(blend(a, b, fy), blend(c, d, fy), fz));
    r.outs = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t e;
    if (rst) begin
      org      = '{0, 0, 0};
      step_inv = 65536;
      dim      = '{32, 32, 32};
      lookup_q.delete();
      errors    <= 0;
      pending   <= 0;
      n_lookups <= 0;
      n_outside <= 0;
    end else begin
      if (cfg_write) begin
        case (gtdl_pkg::cfg_reg_t'(cfg_index))
          gtdl_pkg::CFG_ORIGIN_X: org[0] = longint'(signed'(cfg_data));
          gtdl_pkg::CFG_ORIGIN_Y: org[1] = longint'(signed'(cfg_data));
          gtdl_pkg::CFG_ORIGIN_Z: org[2] = longint'(signed'(cfg_data));
          gtdl_pkg::CFG_INV_STEP: step_inv = longint'(cfg_data[gtdl_pkg::STEP_W-1:0]);
          gtdl_pkg::CFG_GRID_NX:  dim[0] = longint'(cfg_data[gtdl_pkg::DIM_REG_W-1:0]);
          gtdl_pkg::CFG_GRID_NY:  dim[1] = longint'(cfg_data[gtdl_pkg::DIM_REG_W-1:0]);
          gtdl_pkg::CFG_GRID_NZ:  dim[2] = longint'(cfg_data[gtdl_pkg::DIM_REG_W-1:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (action == gtdl_pkg::ACT_WRITE) begin
          grid_mem[cell_address] = cell_value;
        end else begin
          e = predict_lookup(point_x, point_y, point_z);
          lookup_q.insert(lookup_q.size(), e);
          n_lookups <= n_lookups + 1;
          if (e.outs) n_outside <= n_outside + 1;
        end
      end
      if (done) begin
        if (lookup_q.size() == 0) begin
          $display("%0t: result with none expected: distance %h outside %b",
                   $time, distance, outside);
          errors <= errors + 1;
        end else begin
          e = lookup_q.pop_front();
          if (distance !== e.dval || outside !== e.outs) begin
            $display("%0t: mismatch: expected distance %h outside %b, got %h %b",
                     $time, e.dval, e.outs, distance, outside);
            errors <= errors + 1;
          end
        end
      end
      pending <= lookup_q.size();
    end
  end

  final begin
  end
endmodule

// File: tb/sv/grid_trilinear_distance_lookup_tb.sv
module grid_trilinear_distance_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           action = gtdl_pkg::ACT_WRITE;
  logic signed [31:0]             point_x = '0;
  logic signed [31:0]             point_y = '0;
  logic signed [31:0]             point_z = '0;
  logic [gtdl_pkg::ADDR_W-1:0]    cell_address = '0;
  logic signed [31:0]             cell_value = '0;
  logic                           cfg_write = 1'b0;
  logic [gtdl_pkg::CFG_IDX_W-1:0] cfg_index = gtdl_pkg::CFG_ORIGIN_X;
  logic [31:0]                    cfg_data = '0;
  logic                           done;
  logic signed [31:0]             distance;
  logic                           outside;
  int                             errors, pending, n_lookups, n_outside;
  int                             idle_cycles = 0;
  bit                             burst = 0;

  longint org [3];
  longint step_inv;
  longint dim [3];

  always #4 clk = ~clk;

  grid_trilinear_distance_lookup u_top (.*);

  grid_trilinear_distance_lookup_chk u_chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint clamp_dim(longint n);
    return (n > gtdl_pkg::DEF_MAX_DIM) ? gtdl_pkg::DEF_MAX_DIM : n;
  endfunction

  // random point fields are safe only when every cell of the grid is written
  function automatic bit whole_grid_written();
    return clamp_dim(dim[0]) <= 4 && clamp_dim(dim[1]) <= 4 && clamp_dim(dim[2]) <= 4;
  endfunction

  function automatic logic [gtdl_pkg::ADDR_W-1:0] grid_addr(longint x, longint y, longint z);
    return gtdl_pkg::ADDR_W'(x + clamp_dim(dim[0]) * (y + clamp_dim(dim[1]) * z));
  endfunction

  // point on one axis at c cells (Q16.16) from the origin
  function automatic logic [31:0] axis_point(int ax, longint c);
    longint v;
    if (step_inv == 0) return $urandom;
    v = org[ax] + (c * 65536) / step_inv;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  task automatic push(logic act, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                      logic [gtdl_pkg::ADDR_W-1:0] addr, logic [31:0] val);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    action       <= act;
    point_x      <= px;
    point_y      <= py;
    point_z      <= pz;
    cell_address <= addr;
    cell_value   <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic store(longint x, longint y, longint z, logic [31:0] val);
    push(gtdl_pkg::ACT_WRITE, $urandom, $urandom, $urandom, grid_addr(x, y, z), val);
  endtask

  task automatic lookup(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    push(gtdl_pkg::ACT_QUERY, px, py, pz, $urandom, $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // new grid setup, then the low corner block (up to 4x4x4) is filled
  task automatic set_grid(longint ox, longint oy, longint oz, longint inv,
                          longint nx, longint ny, longint nz);
    logic [31:0] vals [7];
    vals = '{32'(ox), 32'(oy), 32'(oz), 32'(inv), 32'(nx), 32'(ny), 32'(nz)};
    for (int r = 0; r < 7; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= gtdl_pkg::cfg_reg_t'(r);
      cfg_data  <= vals[r];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    org = '{ox, oy, oz};
    step_inv = inv;
    dim = '{nx, ny, nz};
    for (int z = 0; z < 4 && z < clamp_dim(dim[2]); z++)
      for (int y = 0; y < 4 && y < clamp_dim(dim[1]); y++)
        for (int x = 0; x < 4 && x < clamp_dim(dim[0]); x++)
          store(x, y, z, $urandom);
  endtask

  task automatic random_items(int count);
    logic [31:0] p [3];
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) burst = ~burst;
      case ($urandom_range(0, 7))
        0: store($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
        1: push(gtdl_pkg::ACT_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: begin
          for (int a = 0; a < 3; a++) begin
            if (whole_grid_written() && $urandom_range(0, 2) == 0) p[a] = $urandom;
            else p[a] = axis_point(a, longint'($urandom_range(0, 222822)) - 65536 - 4096);
          end
          lookup(p[0], p[1], p[2]);
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_grid(0, 0, 0, 65536, 32, 32, 32);
    // directed: value extremes, cell bounds, small negative extrapolation
    store(0, 0, 0, 32'h7FFF_FFFF);
    store(1, 0, 0, 32'h8000_0000);
    push(gtdl_pkg::ACT_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
         grid_addr(2, 0, 0), 32'h0000_0000);
    lookup(0, 0, 0);
    lookup(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    lookup(32'hFFFF_8000, 0, 0);
    lookup(32'hFFFF_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    lookup(32'hFFFF_0000, 0, 0);
    lookup(0, 0, 32'h001F_0000);
    lookup(32'h0002_FFFF, 32'h0002_FFFF, 32'h0002_FFFF);
    lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    lookup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    lookup(32'h0001_8000, 0, 0);
    random_items(30);
    drain();

    set_grid(-64'sd2147483648, 64'sd2147483647, 32'h1234_5678, 65536, 4, 3, 2);
    random_items(40);
    drain();
    set_grid(0, 0, 0, 1, 2, 2, 2);
    random_items(40);
    drain();
    set_grid(longint'(signed'(32'($urandom))), 0, -77, 64'sd2147483647, 63, 5, 40);
    random_items(40);
    drain();
    set_grid(5, -5, 1000, 0, 2, 4, 3);
    random_items(30);
    drain();
    set_grid(0, 0, 0, 65536, 0, 1, 4);
    random_items(30);
    drain();
    for (int ph = 0; ph < 2; ph++) begin
      set_grid(longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
               longint'(signed'(32'($urandom))), $urandom_range(1, 32'h7FFF_FFFF),
               $urandom_range(2, 4), $urandom_range(2, 4), $urandom_range(2, 4));
      random_items(40);
      drain();
    end
    set_grid(longint'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000, 0, 0,
             $urandom_range(4096, 32'h0004_0000),
             $urandom_range(2, 63), $urandom_range(2, 63), $urandom_range(2, 63));
    random_items(40);
    drain();

    $display("Covered %0d lookups (%0d outside) over nine grid setups, incl. extreme origins,",
             n_lookups, n_outside);
    $display("zero and maximal inverse step, dimensions 0, 1, 2, 32 and 63.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
